// ===== rtl/u8sd_pkg.sv =====
// Package for the UTF-8 stream decoder: item types, queue sizes and the
// byte classifier. No dependencies; every other file uses it.
`default_nettype none

package u8sd_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned RES_DEPTH   = 4;
    localparam int unsigned RES_AW      = $clog2(RES_DEPTH);

    localparam logic [20:0] REPL_CP = 21'h00FFFD;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [20:0] code_point;
        logic        was_replaced;
        logic        last_of_run;
        logic        text_done;
    } t_out_item;

    // Byte class as seen when it arrives where no sequence is open.
    typedef enum logic [2:0] {
        CLS_ASCII = 3'd0,
        CLS_LEAD2 = 3'd1,
        CLS_LEAD3 = 3'd2,
        CLS_LEAD4 = 3'd3,
        CLS_BAD   = 3'd4
    } t_cls;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
        t_cls       cls;
    } t_q_item;

    typedef struct packed {
        logic    valid;
        t_q_item item;
    } t_q_head;

    function automatic t_cls classify(input logic [7:0] b);
        t_cls c;
        if (b[7] == 1'b0) begin
            c = CLS_ASCII;
        end else if (b[7:5] == 3'b110) begin
            c = CLS_LEAD2;
        end else if (b[7:4] == 4'b1110) begin
            c = CLS_LEAD3;
        end else if (b[7:3] == 5'b11110) begin
            c = CLS_LEAD4;
        end else begin
            c = CLS_BAD;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/utf8_stream_decoder_unit.sv =====
// UTF-8 stream decoder, top level: front queue, decode engine, result queue.
// A byte passes through the front queue, the decode engine and its lookahead
// register into the result queue. Throughput: one byte per cycle unless a full
// result queue stalls it; replayed held bytes share the single decode step.
// Reset (synchronous, active low) empties both queues and closes any open
// sequence; held byte storage is not cleared.
`default_nettype none

module utf8_stream_decoder_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    output logic                 o_full,
    input  u8sd_pkg::t_in_item   i_item,
    output logic                 o_empty,
    input  wire                  i_pop,
    output u8sd_pkg::t_out_item  o_result
);

    u8sd_pkg::t_q_head   head;
    logic                take;
    logic                res_wr;
    u8sd_pkg::t_out_item res_data;
    logic                res_full;

    u8sd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_item  (i_item),
        .o_head  (head),
        .i_take  (take)
    );

    u8sd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .o_take     (take),
        .o_res_wr   (res_wr),
        .o_res_data (res_data),
        .i_out_full (res_full)
    );

    u8sd_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_wr),
        .i_data  (res_data),
        .o_full  (res_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_data  (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/u8sd_front.sv =====
// Front end of the UTF-8 stream decoder: takes input items, classifies the
// byte and keeps them in a short queue for the decode engine. Uses u8sd_pkg.
`default_nettype none

module u8sd_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    output logic                 o_full,
    input  u8sd_pkg::t_in_item   i_item,
    output u8sd_pkg::t_q_head    o_head,
    input  wire                  i_take
);

    u8sd_pkg::t_q_item r_mem [u8sd_pkg::QUEUE_DEPTH];
    logic [u8sd_pkg::QUEUE_AW-1:0] r_wp;
    logic [u8sd_pkg::QUEUE_AW-1:0] r_rp;
    logic [u8sd_pkg::QUEUE_AW:0]   r_cnt;
    logic                          wr_en;
    logic                          rd_en;
    u8sd_pkg::t_q_item             wr_item;

    assign o_full       = (r_cnt == (u8sd_pkg::QUEUE_AW+1)'(u8sd_pkg::QUEUE_DEPTH));
    assign wr_en        = i_push && !o_full;
    assign rd_en        = i_take && (r_cnt != '0);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.item  = r_mem[r_rp];

    always_comb begin
        wr_item.text_byte   = i_item.text_byte;
        wr_item.end_of_text = i_item.end_of_text;
        wr_item.cls         = u8sd_pkg::classify(i_item.text_byte);
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= wr_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/u8sd_back.sv =====
// Decode engine of the UTF-8 stream decoder: one byte step per cycle unless a
// full result queue stalls it, replay buffer before front queue, with a one-result
// lookahead register that marks the last result of each item. Uses u8sd_pkg.
`default_nettype none

module u8sd_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  u8sd_pkg::t_q_head    i_head,
    output logic                 o_take,
    output logic                 o_res_wr,
    output u8sd_pkg::t_out_item  o_res_data,
    input  wire                  i_out_full
);

    logic [7:0]  r_held [4];
    logic [2:0]  r_hc;
    logic [2:0]  r_nc;
    logic [7:0]  r_rpl [3];
    logic [1:0]  r_rc;
    logic        r_cur_end;

    logic        r_pv;
    logic        r_pc;
    logic        r_pd;
    logic [20:0] r_pcp;
    logic        r_pr;

    logic             src_rpl;
    logic             have;
    logic             go;
    logic [7:0]       b;
    u8sd_pkg::t_cls   cls;
    logic             e;

    logic [7:0]  c [4];
    logic [1:0]  bad;
    logic [20:0] cp;

    logic        res_v;
    logic [20:0] res_cp;
    logic        res_r;
    logic [2:0]  hc_n;
    logic [2:0]  nc_n;
    logic        hold_we;
    logic [1:0]  cnt;
    logic [1:0]  rem_cnt;
    logic [1:0]  rc_n;
    logic [7:0]  nq [3];
    logic        fin;

    assign src_rpl = (r_rc != 2'd0);
    assign have    = src_rpl || i_head.valid;
    assign b       = src_rpl ? r_rpl[0] : i_head.item.text_byte;
    assign cls     = src_rpl ? u8sd_pkg::classify(r_rpl[0]) : i_head.item.cls;
    assign e       = src_rpl ? r_cur_end : i_head.item.end_of_text;
    assign go      = have && !(r_pv && i_out_full);
    assign o_take  = go && !src_rpl;

    // Held bytes with the incoming byte in its slot, and the decode of a
    // sequence that this byte would complete.
    always_comb begin
        c = r_held;
        c[r_hc[1:0]] = b;
        bad = 2'd0;
        for (int k = 3; k >= 1; k--) begin
            if ((3'(k) < r_nc) && (c[k][7:6] != 2'b10)) begin
                bad = 2'(k);
            end
        end
        case (r_nc)
            3'd2:    cp = {10'd0, c[0][4:0], c[1][5:0]};
            3'd3:    cp = {5'd0, c[0][3:0], c[1][5:0], c[2][5:0]};
            default: cp = {c[0][2:0], c[1][5:0], c[2][5:0], c[3][5:0]};
        endcase
    end

    always_comb begin
        res_v   = 1'b0;
        res_cp  = u8sd_pkg::REPL_CP;
        res_r   = 1'b0;
        hc_n    = r_hc;
        nc_n    = r_nc;
        hold_we = 1'b0;
        cnt     = 2'd0;
        if (r_hc == 3'd0) begin
            case (cls)
                u8sd_pkg::CLS_ASCII: begin
                    res_v  = 1'b1;
                    res_cp = {13'd0, b};
                end
                u8sd_pkg::CLS_LEAD2: begin
                    hold_we = 1'b1;
                    hc_n    = 3'd1;
                    nc_n    = 3'd2;
                end
                u8sd_pkg::CLS_LEAD3: begin
                    hold_we = 1'b1;
                    hc_n    = 3'd1;
                    nc_n    = 3'd3;
                end
                u8sd_pkg::CLS_LEAD4: begin
                    hold_we = 1'b1;
                    hc_n    = 3'd1;
                    nc_n    = 3'd4;
                end
                default: begin
                    res_v = 1'b1;
                    res_r = 1'b1;
                end
            endcase
        end else begin
            hold_we = 1'b1;
            if (3'(r_hc + 3'd1) < r_nc) begin
                hc_n = 3'(r_hc + 3'd1);
            end else begin
                hc_n  = 3'd0;
                nc_n  = 3'd0;
                res_v = 1'b1;
                if (bad == 2'd0) begin
                    res_cp = cp;
                end else begin
                    // The bad byte and everything held after it go round again.
                    res_r = 1'b1;
                    cnt   = 2'(r_nc - {1'b0, bad});
                end
            end
        end

        rem_cnt = src_rpl ? 2'(r_rc - 2'd1) : 2'd0;
        rc_n    = 2'(rem_cnt + cnt);
        for (int i = 0; i < 3; i++) begin
            if (3'(i) < {1'b0, cnt}) begin
                nq[i] = c[2'({1'b0, bad} + 3'(i))];
            end else if (3'(i) - {1'b0, cnt} == 3'd0) begin
                nq[i] = r_rpl[1];
            end else begin
                nq[i] = r_rpl[2];
            end
        end
        fin = (rc_n == 2'd0);

        // A string that ends inside an open sequence closes with one replacement.
        if (fin && e && (hc_n != 3'd0)) begin
            res_v  = 1'b1;
            res_cp = u8sd_pkg::REPL_CP;
            res_r  = 1'b1;
            hc_n   = 3'd0;
            nc_n   = 3'd0;
        end
    end

    assign o_res_wr = r_pv && !i_out_full && (r_pc || (go && res_v));
    always_comb begin
        o_res_data.code_point   = r_pcp;
        o_res_data.was_replaced = r_pr;
        o_res_data.last_of_run  = r_pc;
        o_res_data.text_done    = r_pc && r_pd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc <= 3'd0;
            r_nc <= 3'd0;
            r_rc <= 2'd0;
            r_pv <= 1'b0;
            r_pc <= 1'b0;
        end else begin
            if (go) begin
                r_hc <= hc_n;
                r_nc <= nc_n;
                r_rc <= rc_n;
            end
            if (go && res_v) begin
                r_pv <= 1'b1;
                r_pc <= fin;
            end else if (go && fin && r_pv && !r_pc) begin
                r_pc <= 1'b1;
            end else if (o_res_wr) begin
                r_pv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && hold_we) begin
            r_held[r_hc[1:0]] <= b;
        end
        if (go) begin
            r_rpl <= nq;
        end
        if (go && !src_rpl) begin
            r_cur_end <= i_head.item.end_of_text;
        end
        if (go && res_v) begin
            r_pcp <= res_cp;
            r_pr  <= res_r;
            r_pd  <= e;
        end else if (go && fin && r_pv && !r_pc) begin
            r_pd <= e;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/u8sd_res_fifo.sv =====
// Result queue of the UTF-8 stream decoder: holds decoded results until the
// consumer pops them. Uses u8sd_pkg.
`default_nettype none

module u8sd_res_fifo (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_wr,
    input  u8sd_pkg::t_out_item  i_data,
    output logic                 o_full,
    output logic                 o_empty,
    input  wire                  i_pop,
    output u8sd_pkg::t_out_item  o_data
);

    u8sd_pkg::t_out_item         r_mem [u8sd_pkg::RES_DEPTH];
    logic [u8sd_pkg::RES_AW-1:0] r_wp;
    logic [u8sd_pkg::RES_AW-1:0] r_rp;
    logic [u8sd_pkg::RES_AW:0]   r_cnt;
    logic                        wr_en;
    logic                        rd_en;

    assign o_full  = (r_cnt == (u8sd_pkg::RES_AW+1)'(u8sd_pkg::RES_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/u8sd_checker.sv =====
// Port-level checks for the UTF-8 stream decoder, bound to the top level.
// Uses u8sd_pkg.
`default_nettype none

module u8sd_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_full,
    input wire                  o_empty,
    input wire                  i_pop,
    input u8sd_pkg::t_out_item  o_result
);

    // Both queues come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_full && o_empty))
        else $error("queues not empty after reset");

    // A replacement always carries U+FFFD.
    a_repl_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.was_replaced) |-> (o_result.code_point == u8sd_pkg::REPL_CP))
        else $error("replacement item without U+FFFD");

    // The final item of a string is also the last one of its byte.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_result.text_done) |-> o_result.last_of_run)
        else $error("text_done without last_of_run");

    // A waiting result that is not taken stays put.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_result)))
        else $error("result changed while stalled");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .o_full   (o_full),
    .o_empty  (o_empty),
    .i_pop    (i_pop),
    .o_result (o_result)
);

`default_nettype wire
